// File: rtl/slg_pkg.sv
// Shared types and constants for the UTF-8 slug converter.
// Holds the result bundle types and the table for letters after lead byte 0xC3.
`default_nettype none
package slg_pkg;

  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [7:0] LEAD_C5 = 8'hC5;
  localparam logic [7:0] LEAD_E2 = 8'hE2;
  localparam logic [6:0] CH_DASH = 7'h2D;

  // Special codes returned by the 0xC3 table besides plain letters.
  localparam logic [6:0] CODE_NONE = 7'd0;
  localparam logic [6:0] CODE_SS   = 7'd1;
  localparam logic [6:0] CODE_AE   = 7'd2;

  typedef enum logic [2:0] {
    PFX_NONE   = 3'd0,
    PFX_C3     = 3'd1,
    PFX_C5     = 3'd2,
    PFX_E2     = 3'd3,
    PFX_E2_80  = 3'd4
  } prefix_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       has;
    logic       fin;
  } entry_t;

  typedef struct packed {
    entry_t [3:0] ent;
    logic   [2:0] cnt;
  } bundle_t;

  // Base letter of the two-byte character 0xC3, 0x80 + idx.
  function automatic logic [6:0] c3_base(input logic [5:0] idx);
    logic [6:0] r;
    r = CODE_NONE;
    case (idx)
      6'd0, 6'd2, 6'd32, 6'd33, 6'd34, 6'd36:         r = 7'h61; // a
      6'd7, 6'd39:                                    r = 7'h63; // c
      6'd8, 6'd9, 6'd10, 6'd40, 6'd41, 6'd42, 6'd43:  r = 7'h65; // e
      6'd14, 6'd45, 6'd46, 6'd47:                     r = 7'h69; // i
      6'd49:                                          r = 7'h6E; // n
      6'd20, 6'd51, 6'd52, 6'd54:                     r = 7'h6F; // o
      6'd25, 6'd27, 6'd58, 6'd59, 6'd60:              r = 7'h75; // u
      6'd31:                                          r = CODE_SS;
      6'd38:                                          r = CODE_AE;
      default:                                        r = CODE_NONE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/slg_decode.sv
// Byte decoder of the slug converter: prefix, held-dash and non-empty state.
// Builds the result bundle of one accepted byte. Depends on slg_pkg.
`default_nettype none
module slg_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic            merge_tokens,
  input  wire logic [7:0]      in_byte,
  input  wire logic            text_last,
  output slg_pkg::bundle_t     bundle
);
  import slg_pkg::*;

  prefix_t prefix_state, prefix_state_next;
  logic    held_dash, held_dash_next;
  logic    emitted_any, emitted_any_next;

  always_comb begin
    logic       do_fresh;
    logic       put_dash;
    logic       sep_hold;
    logic [1:0] n;
    logic [6:0] l0, l1, m;
    logic       flush;
    logic [2:0] pos;

    do_fresh = 1'b1;
    put_dash = 1'b0;
    sep_hold = 1'b0;
    n = 2'd0;
    l0 = 7'd0;
    l1 = 7'd0;
    prefix_state_next = PFX_NONE;
    m = c3_base(in_byte[5:0]);

    case (prefix_state)
      PFX_C3: begin
        if (in_byte[7:6] == 2'b10 && m != CODE_NONE) begin
          do_fresh = 1'b0;
          if (m == CODE_SS) begin
            n = 2'd2; l0 = 7'h73; l1 = 7'h73;
          end else if (m == CODE_AE) begin
            n = 2'd2; l0 = 7'h61; l1 = 7'h65;
          end else begin
            n = 2'd1; l0 = m;
          end
        end
      end
      PFX_C5: begin
        if (in_byte == 8'h93) begin
          do_fresh = 1'b0;
          n = 2'd2; l0 = 7'h6F; l1 = 7'h65;
        end
      end
      PFX_E2: begin
        if (in_byte == 8'h80) begin
          do_fresh = 1'b0;
          prefix_state_next = PFX_E2_80;
        end
      end
      PFX_E2_80: begin
        if (in_byte == 8'h99 || in_byte == 8'h93) begin
          do_fresh = 1'b0;
          put_dash = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_fresh) begin
      if ((in_byte >= 8'h61 && in_byte <= 8'h7A) || (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
        n = 2'd1; l0 = in_byte[6:0];
      end else if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
        n = 2'd1; l0 = in_byte[6:0] | 7'h20;
      end else if (!merge_tokens && (in_byte == 8'h2D || in_byte == 8'h20 ||
                                     in_byte == 8'h27 || in_byte == 8'h2E)) begin
        sep_hold = emitted_any && !held_dash;
      end else if (in_byte == LEAD_C3) begin
        prefix_state_next = PFX_C3;
      end else if (in_byte == LEAD_C5) begin
        prefix_state_next = PFX_C5;
      end else if (in_byte == LEAD_E2) begin
        prefix_state_next = PFX_E2;
      end
    end

    flush = held_dash && (n != 2'd0 || put_dash);
    if (put_dash || sep_hold) held_dash_next = 1'b1;
    else if (n != 2'd0)       held_dash_next = 1'b0;
    else                      held_dash_next = held_dash;
    emitted_any_next = emitted_any || n != 2'd0 || put_dash;

    // Pack held dash, letters and the closing result in order.
    bundle = '0;
    pos = 3'd0;
    if (flush) begin
      bundle.ent[pos[1:0]] = '{ch: CH_DASH, has: 1'b1, fin: 1'b0};
      pos = pos + 3'd1;
    end
    if (n != 2'd0) begin
      bundle.ent[pos[1:0]] = '{ch: l0, has: 1'b1, fin: 1'b0};
      pos = pos + 3'd1;
    end
    if (n == 2'd2) begin
      bundle.ent[pos[1:0]] = '{ch: l1, has: 1'b1, fin: 1'b0};
      pos = pos + 3'd1;
    end
    if (text_last) begin
      bundle.ent[pos[1:0]] = '{ch: 7'd0, has: 1'b0, fin: 1'b1};
      pos = pos + 3'd1;
      held_dash_next = 1'b0;
      emitted_any_next = 1'b0;
      prefix_state_next = PFX_NONE;
    end
    bundle.cnt = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_state <= PFX_NONE;
      held_dash    <= 1'b0;
      emitted_any  <= 1'b0;
    end else if (accept) begin
      prefix_state <= prefix_state_next;
      held_dash    <= held_dash_next;
      emitted_any  <= emitted_any_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/slg_emit.sv
// Result register of the slug converter: holds one byte's bundle and sends
// its results one per cycle while out_stall is low. Depends on slg_pkg.
`default_nettype none
module slg_emit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire slg_pkg::bundle_t bundle,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [6:0]            out_char,
  output logic                  has_char,
  output logic                  run_last,
  output logic                  text_end
);
  import slg_pkg::*;

  entry_t [3:0] ents;
  logic   [2:0] cnt;
  logic   [1:0] idx;
  logic         busy;
  logic         take;
  logic         at_end;

  assign at_end    = ({1'b0, idx} + 3'd1) == cnt;
  assign take      = busy && !out_stall;
  assign can_load  = !busy || (take && at_end);
  assign out_valid = busy;
  assign out_char  = ents[idx].ch;
  assign has_char  = ents[idx].has;
  assign text_end  = ents[idx].fin;
  assign run_last  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
      cnt  <= 3'd0;
    end else if (load && bundle.cnt != 3'd0) begin
      busy <= 1'b1;
      idx  <= 2'd0;
      cnt  <= bundle.cnt;
    end else if (take && at_end) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && bundle.cnt != 3'd0) begin
      ents <= bundle.ent;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 3'd0)
    else $error("busy with an empty bundle");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> {1'b0, idx} < cnt)
    else $error("result index past bundle count");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (busy && text_end) |-> run_last)
    else $error("closing result not last of its byte");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !at_end && !load) |=> (busy && idx == $past(idx) + 2'd1))
    else $error("index did not advance after transaction");

endmodule
`default_nettype wire

// File: rtl/utf8_text_slugifier.sv
// Top level of the UTF-8 to URL slug converter.
// Latency: first result of a byte appears the cycle after the byte is taken.
// Throughput: one byte per cycle while out_stall is low; a byte with k > 1 results stalls
// the input until its last result is taken, as the result register sends one result per cycle.
// Reset: synchronous rst clears prefix, held dash, non-empty flag, merge_tokens.
// Depends on slg_pkg, slg_decode and slg_emit.
`default_nettype none
module utf8_text_slugifier (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_char,
  output logic            has_char,
  output logic            run_last,
  output logic            text_end
);
  import slg_pkg::*;

  logic    merge_tokens;
  logic    can_load;
  logic    accept;
  bundle_t bundle;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_tokens <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      merge_tokens <= cfg_data;
    end
  end

  slg_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .merge_tokens (merge_tokens),
    .in_byte      (in_byte),
    .text_last    (text_last),
    .bundle       (bundle)
  );

  slg_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .has_char  (has_char),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule
`default_nettype wire

// File: tb/utf8_text_slugifier_tb.sv
// Self-checking testbench for utf8_text_slugifier: UTF-8 bytes in, slug characters out.
// Predicts each byte's results in-line and compares them in order against the output port.
// Depends on slg_pkg and the utf8_text_slugifier RTL.
`timescale 1ns / 100ps

module utf8_text_slugifier_tb;
  import slg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [7:0] CONT_80   = 8'h80;
  localparam logic [7:0] OE_TAIL   = 8'h93;
  localparam logic [7:0] RSQ_TAIL  = 8'h99;
  localparam logic [7:0] NDASH_TAIL = 8'h93;
  localparam logic [7:0] SEP_SPACE = " ";
  localparam logic [7:0] SEP_DASH  = "-";
  localparam logic [7:0] SEP_APOS  = "'";
  localparam logic [7:0] SEP_DOT   = ".";

  // Letter after lead 0xC3, indexed by the low six bits of the second byte.
  localparam logic [7:0] MARK_NONE = ".";
  localparam logic [7:0] MARK_SS   = "S";
  localparam logic [7:0] MARK_AE   = "A";
  localparam logic [511:0] C3_LETTERS = {"a.a....c", "eee...i.", "....o...", ".u.u...S",
                                         "aaa.a.Ac", "eeee.iii", ".n.oo.o.", "..uuu..."};

  typedef struct {
    logic [7:0] b;
    bit         eot;
  } text_byte_t;

  typedef struct {
    logic [6:0] ch;
    bit         has;
    bit         last;
    bit         fin;
  } slug_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       text_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       has_char;
  logic       run_last;
  logic       text_end;

  text_byte_t byte_queue[$];
  slug_res_t  slug_expected[$];
  slug_res_t  step_res[$];

  // predictor state
  prefix_t pfx = PFX_NONE;
  bit      dash_held = 1'b0;
  bit      slug_nonempty = 1'b0;
  bit      merge_sep = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors = 0;
  int n_bytes = 0;
  int n_chars = 0;
  int n_texts = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  utf8_text_slugifier uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .text_last(text_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .has_char(has_char),
    .run_last(run_last),
    .text_end(text_end)
  );

  always #4 clk = ~clk;

  task automatic note_mismatch(string what, int got, int want);
    n_errors++;
    $display("[%0t] %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
  endtask

  task automatic push_res(logic [6:0] ch, bit has, bit fin);
    slug_res_t r;
    r.ch = ch;
    r.has = has;
    r.last = 1'b0;
    r.fin = fin;
    step_res.push_back(r);
  endtask

  task automatic release_dash();
    if (dash_held) begin
      push_res(CH_DASH, 1'b1, 1'b0);
      dash_held = 1'b0;
    end
  endtask

  task automatic send_letter(logic [6:0] ch);
    release_dash();
    push_res(ch, 1'b1, 1'b0);
    slug_nonempty = 1'b1;
  endtask

  task automatic plain_byte(logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
      send_letter(b[6:0]);
    end else if (b >= "A" && b <= "Z") begin
      send_letter(b[6:0] + 7'd32);
    end else if (!merge_sep && (b == SEP_DASH || b == SEP_SPACE || b == SEP_APOS ||
                                b == SEP_DOT)) begin
      if (slug_nonempty && !dash_held) dash_held = 1'b1;
    end else if (b == LEAD_C3) begin
      pfx = PFX_C3;
    end else if (b == LEAD_C5) begin
      pfx = PFX_C5;
    end else if (b == LEAD_E2) begin
      pfx = PFX_E2;
    end
  endtask

  // Work out the results of one accepted byte and queue them.
  task automatic slug_predict(logic [7:0] b, bit eot);
    prefix_t    st;
    logic [7:0] mark;
    bit         done;
    st = pfx;
    pfx = PFX_NONE;
    done = 1'b0;
    step_res = {};
    case (st)
      PFX_C3: begin
        if (b[7:6] == 2'b10) begin
          mark = C3_LETTERS[8*(63 - b[5:0]) +: 8];
          if (mark == MARK_SS) begin
            send_letter(7'("s"));
            send_letter(7'("s"));
          end else if (mark == MARK_AE) begin
            send_letter(7'("a"));
            send_letter(7'("e"));
          end else if (mark != MARK_NONE) begin
            send_letter(mark[6:0]);
          end
          done = (mark != MARK_NONE);
        end
      end
      PFX_C5: begin
        if (b == OE_TAIL) begin
          send_letter(7'("o"));
          send_letter(7'("e"));
          done = 1'b1;
        end
      end
      PFX_E2: begin
        if (b == CONT_80) begin
          pfx = PFX_E2_80;
          done = 1'b1;
        end
      end
      PFX_E2_80: begin
        if (b == RSQ_TAIL || b == NDASH_TAIL) begin
          release_dash();
          dash_held = 1'b1;
          slug_nonempty = 1'b1;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (!done) plain_byte(b);
    if (eot) begin
      dash_held = 1'b0;
      push_res(7'd0, 1'b0, 1'b1);
      pfx = PFX_NONE;
      slug_nonempty = 1'b0;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) slug_expected.push_back(step_res[i]);
  endtask

  // Driver: advance to the next byte once the current transaction is taken.
  always @(posedge clk) begin
    text_byte_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        slug_predict(in_byte, text_last);
        n_bytes++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_byte <= nb.b;
          text_last <= nb.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    slug_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (slug_expected.size() == 0) begin
          note_mismatch("result with nothing expected, out_char", out_char, 0);
        end else begin
          want = slug_expected.pop_front();
          if (out_char !== want.ch) note_mismatch("out_char", out_char, want.ch);
          if (has_char !== want.has) note_mismatch("has_char", has_char, want.has);
          if (run_last !== want.last) note_mismatch("run_last", run_last, want.last);
          if (text_end !== want.fin) note_mismatch("text_end", text_end, want.fin);
          if (want.has) n_chars++;
          if (want.fin) n_texts++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("utf8_text_slugifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_byte(logic [7:0] b, bit eot);
    text_byte_t t;
    t.b = b;
    t.eot = eot;
    byte_queue.push_back(t);
  endtask

  // One character of random text; eot goes on its final byte.
  task automatic add_symbol(bit eot);
    int kind;
    kind = $urandom_range(99);
    if (kind < 35) begin
      case ($urandom_range(2))
        0: add_byte(8'("a" + $urandom_range(25)), eot);
        1: add_byte(8'("A" + $urandom_range(25)), eot);
        default: add_byte(8'("0" + $urandom_range(9)), eot);
      endcase
    end else if (kind < 50) begin
      case ($urandom_range(3))
        0: add_byte(SEP_SPACE, eot);
        1: add_byte(SEP_DASH, eot);
        2: add_byte(SEP_APOS, eot);
        default: add_byte(SEP_DOT, eot);
      endcase
    end else if (kind < 75) begin
      case ($urandom_range(3))
        0, 1: begin
          add_byte(LEAD_C3, 1'b0);
          add_byte({2'b10, 6'($urandom_range(63))}, eot);
        end
        2: begin
          add_byte(LEAD_C5, 1'b0);
          add_byte(OE_TAIL, eot);
        end
        default: begin
          add_byte(LEAD_E2, 1'b0);
          add_byte(CONT_80, 1'b0);
          add_byte($urandom_range(1) ? RSQ_TAIL : NDASH_TAIL, eot);
        end
      endcase
    end else if (kind < 85) begin
      // broken or unfinished sequence
      case ($urandom_range(2))
        0: add_byte(LEAD_C3, 1'b0);
        1: add_byte(LEAD_C5, 1'b0);
        default: begin
          add_byte(LEAD_E2, 1'b0);
          if ($urandom_range(1)) add_byte(CONT_80, 1'b0);
        end
      endcase
      add_byte(8'($urandom_range(255)), eot);
    end else begin
      add_byte(8'($urandom_range(255)), eot);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_queue.size() > 0 || in_valid || slug_expected.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_merge(bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    merge_sep = v;
    n_cfg++;
  endtask

  task automatic random_phase(bit merge, int s_pct, int r_pct, int n_items);
    int n_words;
    write_merge(merge);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (byte_queue.size() < n_items) begin
      n_words = $urandom_range(1, 10);
      for (int i = 0; i < n_words; i++) add_symbol(i == n_words - 1);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 60;
    write_merge(1'b0);
    // leading separator, letters, separators, two-byte letters, curly quote, en dash
    add_byte(SEP_DASH, 1'b0);
    add_byte("A", 1'b0);
    add_byte("z", 1'b0);
    add_byte("9", 1'b0);
    add_byte(SEP_SPACE, 1'b0);
    add_byte(SEP_DOT, 1'b0);
    add_byte(LEAD_C3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(LEAD_C3, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(LEAD_C3, 1'b0);
    add_byte(8'hA6, 1'b0);
    add_byte(LEAD_C5, 1'b0);
    add_byte(OE_TAIL, 1'b0);
    add_byte(LEAD_E2, 1'b0);
    add_byte(CONT_80, 1'b0);
    add_byte(RSQ_TAIL, 1'b0);
    add_byte(LEAD_E2, 1'b0);
    add_byte(CONT_80, 1'b0);
    add_byte(NDASH_TAIL, 1'b0);
    // broken prefixes: plain byte after lead, new lead after lead
    add_byte(LEAD_C3, 1'b0);
    add_byte("A", 1'b0);
    add_byte(LEAD_E2, 1'b0);
    add_byte(LEAD_C3, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    // trailing dash dropped, then a text that ends inside a prefix
    add_byte(SEP_DASH, 1'b1);
    add_byte(LEAD_C3, 1'b1);
    wait_drained();

    write_merge(1'b1);
    add_byte("x", 1'b0);
    add_byte(SEP_SPACE, 1'b0);
    add_byte("y", 1'b1);
    wait_drained();

    random_phase(1'b1, 9, 60, 54);
    random_phase(1'b0, 60, 9, 54);
    random_phase(1'b1, 0, 0, 54);
    random_phase(1'b0, 0, 0, 54);

    if (slug_expected.size() != 0)
      note_mismatch("results still expected", slug_expected.size(), 0);
    $display("run covered %0d input bytes, %0d slug characters, %0d texts",
             n_bytes, n_chars, n_texts);
    $display("%0d merge_tokens writes, three idle patterns, %0d field errors",
             n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("utf8_text_slugifier: match");
    end else begin
      $display("utf8_text_slugifier: mismatch");
    end
    $finish;
  end

endmodule

// File: utf8_text_slugifier.f
rtl/slg_pkg.sv
rtl/slg_decode.sv
rtl/slg_emit.sv
rtl/utf8_text_slugifier.sv
tb/utf8_text_slugifier_tb.sv
